// ===== hw/rtl/photon_efficiency_interpolator_unit_macros.svh =====
// Assertion macros shared by the RTL of the efficiency interpolator.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef PHOTON_EFFICIENCY_INTERPOLATOR_UNIT_MACROS_SVH
`define PHOTON_EFFICIENCY_INTERPOLATOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define PEI_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PEI_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/pei_pkg.sv =====
package pei_pkg;

	localparam int TABLE_POINTS = 64;
	localparam int IDX_W        = $clog2(TABLE_POINTS);
	localparam int CNT_W        = 7;
	localparam int N_W          = (CNT_W > IDX_W) ? CNT_W : IDX_W + 1;

	localparam int PIDX_W = 6;
	localparam int WL_W   = 24;
	localparam int EFF_W  = 16;
	localparam int EN_W   = 16;

	localparam int S_DATA_W   = 64;
	localparam int M_DATA_W   = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	// Wavelength divider: 31-bit dividend, 25 quotient bits.
	localparam int NUM_W  = 31;
	localparam int DEN_W  = 23;
	localparam int WLQ_W  = 25;
	// Shared restoring divider.
	localparam int REM_W  = 25;
	localparam int DVD_W  = 42;
	localparam int DCNT_W = 5;
	// Interpolation.
	localparam int IQ_W   = 17;
	localparam int PROD_W = 43;

	localparam logic [NUM_W-1:0] WL_NUMERATOR    = 31'd1983747168;
	localparam logic [EFF_W-1:0] FIXED_POINT_TWO = 16'd13107;
	localparam logic [EFF_W-1:0] HALF_FULL_SCALE = 16'h7FFF;

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LOADED = 1'b1;

	typedef struct packed {
		logic [WL_W-1:0]  wl;
		logic [EFF_W-1:0] eff;
	} entry_t;

	// Input tdata layout, lowest field in the lowest bits.
	typedef struct packed {
		logic [1:0]        pad;
		logic [EN_W-1:0]   energy;
		logic [EFF_W-1:0]  eff;
		logic [WL_W-1:0]   wl;
		logic [PIDX_W-1:0] idx;
	} in_item_t;

endpackage

// ===== hw/rtl/photon_efficiency_interpolator_unit.sv =====
// Load transfer: no result; loads may arrive back to back.
// Query: goes straight to output when the table is not loaded or the energy is
// zero; otherwise the result waits on the 25-step wavelength division, the scan
// of one table entry per cycle through the single read port, and the 17-step
// interpolation division. One query at a time.
// arst_n clears control and the output valid; tables are undefined until loaded.
module photon_efficiency_interpolator_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	// Input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [5:0] point_index, [29:6] point_wavelength, [45:30] point_efficiency,
	// [61:46] photon_energy, [63:62] zero
	input  logic [pei_pkg::S_DATA_W-1:0]     s_axis_tdata,
	// [0] opcode
	input  logic                             s_axis_tuser,
	// Result stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [15:0] detect_efficiency
	output logic [pei_pkg::M_DATA_W-1:0]     m_axis_tdata,
	// Configuration writes
	input  logic                             cfg_we,
	input  logic [pei_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pei_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import pei_pkg::*;
	`include "photon_efficiency_interpolator_unit_macros.svh"

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIV  = 4'd1;
	localparam logic [3:0] S_LAST = 4'd2;
	localparam logic [3:0] S_SCAN = 4'd3;
	localparam logic [3:0] S_MUL  = 4'd4;
	localparam logic [3:0] S_ABS  = 4'd5;
	localparam logic [3:0] S_DIVI = 4'd6;
	localparam logic [3:0] S_ADJ  = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	// Control state
	logic [3:0]        state_q;
	logic [IDX_W-1:0]  k_q;
	logic [DCNT_W-1:0] cnt_q;
	logic              m_valid_q;
	logic [CNT_W-1:0]  point_count_q;
	logic              table_loaded_q;

	// Datapath registers
	logic [REM_W-1:0]         rem_q;
	logic [DVD_W-1:0]         dvd_q;
	logic [REM_W-1:0]         dvs_q;
	logic [WLQ_W-1:0]         quo_q;
	logic [WLQ_W-1:0]         wl_q;
	logic [WL_W-1:0]          wlast_q;
	logic [WL_W-1:0]          w0_q;
	logic [WL_W-1:0]          w1_q;
	logic [EFF_W-1:0]         e0_q;
	logic [EFF_W-1:0]         e1_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [REM_W-1:0]  span_q;
	logic                     neg_q;
	logic [EFF_W-1:0]         res_q;
	logic [M_DATA_W-1:0]      m_data_q;

	in_item_t in_item;
	logic     s_fire;
	logic     out_free;

	assign in_item       = in_item_t'(s_axis_tdata);
	assign s_axis_tready = (state_q == S_IDLE);
	assign s_fire        = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	// Last breakpoint index in use, with the count clamped to [2, TABLE_POINTS].
	logic [N_W-1:0]   n_ext;
	logic [IDX_W-1:0] n_last;

	always_comb begin
		n_ext = N_W'(point_count_q);
		if (n_ext < N_W'(2)) begin
			n_last = IDX_W'(1);
		end else if (n_ext > N_W'(TABLE_POINTS)) begin
			n_last = IDX_W'(TABLE_POINTS - 1);
		end else begin
			n_last = IDX_W'(n_ext - N_W'(1));
		end
	end

	// Breakpoint table: wavelength and efficiency side by side.
	logic                       ram_we;
	logic [IDX_W-1:0]           ram_waddr;
	entry_t                     ram_wdata;
	logic [IDX_W-1:0]           ram_raddr;
	logic [$bits(entry_t)-1:0]  ram_rdata;
	entry_t                     rd_entry;

	assign ram_we          = s_fire && (s_axis_tuser == OP_LOAD)
	                         && (32'(in_item.idx) < TABLE_POINTS);
	assign ram_waddr       = IDX_W'(in_item.idx);
	assign ram_wdata.wl    = in_item.wl;
	assign ram_wdata.eff   = in_item.eff;
	assign rd_entry        = entry_t'(ram_rdata);

	// Prefetch the last breakpoint while dividing, entry 0 next, then walk up.
	always_comb begin
		case (state_q)
			S_LAST:  ram_raddr = '0;
			S_SCAN:  ram_raddr = IDX_W'(k_q + IDX_W'(1));
			default: ram_raddr = n_last;
		endcase
	end

	pei_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(TABLE_POINTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Wavelength operands: round(19837471.68 / E) = (N + 50E) / (100E).
	logic [DEN_W-1:0] den;
	logic [NUM_W-1:0] num;

	assign den = DEN_W'(in_item.energy) * DEN_W'(100);
	assign num = WL_NUMERATOR + NUM_W'(den[DEN_W-1:1]);

	// Shared restoring divider: one quotient bit per cycle.
	logic [REM_W:0]   r_sh;
	logic             q_bit;
	logic [REM_W-1:0] rem_step;

	always_comb begin
		r_sh     = {rem_q, dvd_q[DVD_W-1]};
		q_bit    = (r_sh >= {1'b0, dvs_q});
		rem_step = q_bit ? REM_W'(r_sh - {1'b0, dvs_q}) : REM_W'(r_sh);
	end

	// Scan compare: first interval with w[k-1] < wl <= w[k]; wl on the first
	// breakpoint takes interval 0.
	logic out_of_range;
	logic hit;

	always_comb begin
		out_of_range = ({1'b0, rd_entry.wl} > wl_q) || (wl_q > {1'b0, wlast_q});
		hit = (({1'b0, w0_q} < wl_q) && (wl_q <= {1'b0, rd_entry.wl}))
		      || ((k_q == IDX_W'(1)) && (wl_q == {1'b0, w0_q}));
	end

	// Interpolation arithmetic.
	logic signed [WLQ_W:0]    diff;
	logic signed [EFF_W:0]    ediff;
	logic signed [PROD_W-1:0] prod_n;
	logic signed [REM_W-1:0]  span_n;
	logic [DVD_W-1:0]         a_mag;
	logic [REM_W-1:0]         d_mag;
	logic                     ovf;
	logic signed [IQ_W+1:0]   qs;
	logic signed [IQ_W+1:0]   v;
	logic [EFF_W-1:0]         v_clamp;

	always_comb begin
		diff   = $signed({1'b0, wl_q}) - $signed({2'b00, w0_q});
		ediff  = $signed({1'b0, e1_q}) - $signed({1'b0, e0_q});
		prod_n = PROD_W'(diff) * PROD_W'(ediff);
		span_n = $signed({1'b0, w1_q}) - $signed({1'b0, w0_q});
		a_mag  = prod_q[PROD_W-1] ? DVD_W'(-prod_q) : DVD_W'(prod_q);
		d_mag  = span_q[REM_W-1] ? REM_W'(-span_q) : REM_W'(span_q);
		// Quotient of 2^17 or more saturates either way.
		ovf    = (a_mag >= {d_mag, {IQ_W{1'b0}}});
		qs     = neg_q ? -$signed({2'b00, quo_q[IQ_W-1:0]})
		               :  $signed({2'b00, quo_q[IQ_W-1:0]});
		v      = $signed({3'b000, e0_q}) + qs;
		if (v[IQ_W+1]) begin
			v_clamp = '0;
		end else if (v[IQ_W:EFF_W] != 2'b00) begin
			v_clamp = '1;
		end else begin
			v_clamp = v[EFF_W-1:0];
		end
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			k_q            <= '0;
			cnt_q          <= '0;
			m_valid_q      <= 1'b0;
			point_count_q  <= CNT_W'(2);
			table_loaded_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_POINT_COUNT:  point_count_q  <= cfg_data;
					CFG_TABLE_LOADED: table_loaded_q <= cfg_data[0];
				endcase
			end

			if (state_q == S_OUT && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_fire && s_axis_tuser == OP_QUERY) begin
						if (!table_loaded_q || in_item.energy == '0) begin
							state_q <= S_OUT;
						end else begin
							cnt_q   <= DCNT_W'(WLQ_W);
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					cnt_q <= cnt_q - DCNT_W'(1);
					if (cnt_q == DCNT_W'(1)) begin
						state_q <= S_LAST;
					end
				end
				S_LAST: begin
					k_q     <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (k_q == '0) begin
						if (out_of_range) begin
							state_q <= S_OUT;
						end else begin
							k_q <= IDX_W'(1);
						end
					end else if (hit || k_q == n_last) begin
						state_q <= S_MUL;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				S_MUL: begin
					state_q <= (span_n == '0) ? S_OUT : S_ABS;
				end
				S_ABS: begin
					if (ovf) begin
						state_q <= S_OUT;
					end else begin
						cnt_q   <= DCNT_W'(IQ_W);
						state_q <= S_DIVI;
					end
				end
				S_DIVI: begin
					cnt_q <= cnt_q - DCNT_W'(1);
					if (cnt_q == DCNT_W'(1)) begin
						state_q <= S_ADJ;
					end
				end
				S_ADJ: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					// Hold the result until the output register frees up.
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && out_free) begin
			m_data_q <= res_q;
		end

		case (state_q)
			S_IDLE: begin
				if (!table_loaded_q) begin
					res_q <= FIXED_POINT_TWO;
				end else begin
					res_q <= '0;
				end
				rem_q <= REM_W'(num[NUM_W-1:WLQ_W]);
				dvd_q <= {num[WLQ_W-1:0], {(DVD_W - WLQ_W){1'b0}}};
				dvs_q <= REM_W'(den);
				quo_q <= '0;
			end
			S_DIV, S_DIVI: begin
				rem_q <= rem_step;
				dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
				quo_q <= {quo_q[WLQ_W-2:0], q_bit};
			end
			S_LAST: begin
				wl_q    <= quo_q;
				wlast_q <= rd_entry.wl;
			end
			S_SCAN: begin
				// Out-of-range result is zero; res_q already holds it.
				if (k_q != '0 && (hit || k_q == n_last)) begin
					w1_q <= rd_entry.wl;
					e1_q <= rd_entry.eff;
				end else begin
					w0_q <= rd_entry.wl;
					e0_q <= rd_entry.eff;
				end
			end
			S_MUL: begin
				prod_q <= prod_n;
				span_q <= span_n;
				res_q  <= e0_q >> 1;
			end
			S_ABS: begin
				neg_q <= prod_q[PROD_W-1] ^ span_q[REM_W-1];
				res_q <= (prod_q[PROD_W-1] ^ span_q[REM_W-1]) ? '0 : HALF_FULL_SCALE;
				rem_q <= a_mag[DVD_W-1:IQ_W];
				dvd_q <= {a_mag[IQ_W-1:0], {(DVD_W - IQ_W){1'b0}}};
				dvs_q <= d_mag;
				quo_q <= '0;
			end
			S_ADJ: begin
				res_q <= v_clamp >> 1;
			end
			default: begin
			end
		endcase
	end

	`PEI_ASSERT_NOW(a_load_only_idle, ram_we, state_q == S_IDLE,
		"table write outside idle")
	`PEI_ASSERT_NOW(a_scan_bound, state_q == S_SCAN, k_q <= n_last,
		"scan ran past last breakpoint")
	`PEI_ASSERT_NOW(a_rem_below_dvs, state_q == S_DIV || state_q == S_DIVI,
		rem_q < dvs_q, "divider remainder not below divisor")
	`PEI_ASSERT_NOW(a_quot_fits, state_q == S_ADJ, quo_q[WLQ_W-1:IQ_W] == '0,
		"interpolation quotient overflow")
	`PEI_ASSERT_NEXT(a_out_issue, state_q == S_OUT && out_free,
		m_valid_q && state_q == S_IDLE, "result not issued from output state")

endmodule

// ===== hw/rtl/pei_ram.sv =====
module pei_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import pei_pkg::*;

	// Wavelengths (1/16 nm) that the block derives from 1000, 800 and 500 meV.
	localparam int unsigned WL_AT_1000MEV = 19837;
	localparam int unsigned WL_AT_800MEV  = 24797;
	localparam int unsigned WL_AT_500MEV  = 39675;
	localparam int unsigned WL_MAX        = 24'hFFFFFF;
	// Wavelength times energy, rounded; turns a target wavelength into an energy.
	localparam int unsigned WL_ENERGY_PRODUCT = 19837472;
	localparam int unsigned RANDOM_ITEMS      = 1750;
	// Long enough for the slowest query to finish, with a margin.
	localparam int          SETTLE_CYCLES     = 130;
	localparam int          LONG_HOLD         = 300;

	// Scoreboard: mirrors the breakpoint tables and the two registers, and
	// holds the efficiencies that are still to come out of the result stream.
	class efficiency_scoreboard;
		logic [WL_W-1:0]  wavelength_of [TABLE_POINTS];
		logic [EFF_W-1:0] efficiency_of [TABLE_POINTS];
		logic [CNT_W-1:0] point_count;
		logic             table_loaded;
		logic [EFF_W-1:0] awaited_efficiency [$];
		int               mismatches;

		function new();
			foreach (wavelength_of[i]) begin
				wavelength_of[i] = '0;
				efficiency_of[i] = '0;
			end
			point_count  = CNT_W'(2);
			table_loaded = 1'b0;
			mismatches   = 0;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			case (index)
				CFG_POINT_COUNT:  point_count = data[CNT_W-1:0];
				CFG_TABLE_LOADED: table_loaded = data[0];
				default: ;
			endcase
		endfunction

		function logic [EFF_W-1:0] interpolate_efficiency(logic [EN_W-1:0] energy);
			longint unsigned wl;
			int unsigned     used;
			int unsigned     j;
			longint          w0, w1, e0, e1, span, v;
			if (!table_loaded)
				return FIXED_POINT_TWO;
			if (energy == '0)
				return '0;
			wl = (64'(WL_NUMERATOR) + 64'(energy) * 50) / (64'(energy) * 100);
			used = point_count;
			if (used < 2)
				used = 2;
			if (used > TABLE_POINTS)
				used = TABLE_POINTS;
			if (wl < wavelength_of[0] || wl > wavelength_of[used-1])
				return '0;
			j = used - 2;
			if (wl == wavelength_of[0]) begin
				j = 0;
			end else begin
				for (int k = 0; k + 1 < used; k++) begin
					if (wavelength_of[k] < wl && wl <= wavelength_of[k+1]) begin
						j = k;
						break;
					end
				end
			end
			w0 = wavelength_of[j];
			w1 = wavelength_of[j+1];
			e0 = efficiency_of[j];
			e1 = efficiency_of[j+1];
			span = w1 - w0;
			if (span == 0)
				return EFF_W'(e0 >>> 1);
			v = e0 + ((signed'(wl) - w0) * (e1 - e0)) / span;
			if (v < 0)
				v = 0;
			if (v > 65535)
				v = 65535;
			return EFF_W'(v >>> 1);
		endfunction

		function void note_transfer(logic op, in_item_t item);
			if (op == OP_LOAD) begin
				wavelength_of[item.idx] = item.wl;
				efficiency_of[item.idx] = item.eff;
			end else begin
				awaited_efficiency.push_back(interpolate_efficiency(item.energy));
			end
		endfunction

		function void check_result(logic [EFF_W-1:0] got);
			logic [EFF_W-1:0] want;
			if (awaited_efficiency.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: detect_efficiency %0d, nothing awaited", got);
			end else begin
				want = awaited_efficiency.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("detect_efficiency mismatch: expected %0d, got %0d", want, got);
				end
			end
		endfunction

		function int outstanding();
			return awaited_efficiency.size();
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [S_DATA_W-1:0]   s_axis_tdata;
	logic                  s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [M_DATA_W-1:0]   m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	efficiency_scoreboard board;
	// 0: no idling, 1: light idling, 2: heavy idling; shared by both sides.
	int pace;
	// Set by the stimulus to make the result side hold off for a long stretch.
	bit hold_request;

	photon_efficiency_interpolator_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Idle length for either side: mostly none or short, now and then long.
	function automatic int idle_cycles();
		int r;
		r = $urandom_range(0, 99);
		if (pace == 0 || r < ((pace == 1) ? 70 : 40))
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(12, 40);
	endfunction

	// Offer one item and hold it until the transfer happens; returns on that
	// edge with tvalid still high, so the next call can keep it up.
	task automatic push_item(input logic op, input in_item_t item);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= item;
		s_axis_tuser  <= op;
		do
			@(posedge clk);
		while (!s_axis_tready);
		board.note_transfer(op, item);
	endtask

	// Load one breakpoint; the energy field is don't-care, so fill it randomly.
	task automatic push_load(input int unsigned slot, input int unsigned wl,
			input int unsigned eff);
		in_item_t item;
		item.pad    = '0;
		item.idx    = PIDX_W'(slot);
		item.wl     = WL_W'(wl);
		item.eff    = EFF_W'(eff);
		item.energy = EN_W'($urandom_range(0, 65535));
		push_item(OP_LOAD, item);
	endtask

	task automatic push_query_item(input in_item_t item);
		push_item(OP_QUERY, item);
	endtask

	// Query one energy; the breakpoint fields are don't-care.
	task automatic push_query(input int unsigned energy);
		in_item_t item;
		item.pad    = '0;
		item.idx    = PIDX_W'($urandom_range(0, 63));
		item.wl     = WL_W'($urandom());
		item.eff    = EFF_W'($urandom_range(0, 65535));
		item.energy = EN_W'(energy);
		push_query_item(item);
	endtask

	// Drop the input, wait for every awaited result, then let a trailing
	// load or query finish inside the block before touching registers.
	task automatic drain_and_settle();
		s_axis_tvalid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers on consecutive edges; only called while idle.
	task automatic write_config(input logic [CNT_W-1:0] count, input logic loaded);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_POINT_COUNT;
		cfg_data  <= CFG_DATA_W'(count);
		@(posedge clk);
		board.write_register(CFG_POINT_COUNT, CFG_DATA_W'(count));
		cfg_index <= CFG_TABLE_LOADED;
		cfg_data  <= CFG_DATA_W'(loaded);
		@(posedge clk);
		board.write_register(CFG_TABLE_LOADED, CFG_DATA_W'(loaded));
		cfg_we <= 1'b0;
	endtask

	// Result side: check every transfer, stall at random, and honor a long
	// hold-off on request, counted here in cycles.
	initial begin
		int stall_left;
		int g;
		stall_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
				board.check_result(m_axis_tdata);
			if (hold_request) begin
				hold_request = 1'b0;
				stall_left   = LONG_HOLD;
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				g = idle_cycles();
				if (g == 0) begin
					m_axis_tready <= 1'b1;
				end else begin
					m_axis_tready <= 1'b0;
					stall_left = g - 1;
				end
			end
		end
	end

	// Stimulus.
	initial begin
		int unsigned      random_items;
		int unsigned      phase;
		int unsigned      used;
		int unsigned      first_wl;
		int unsigned      last_wl;
		int unsigned      wl_acc;
		int unsigned      spread;
		int unsigned      step_max;
		int unsigned      target;
		int unsigned      energy;
		int unsigned      eff;
		int unsigned      queries;
		int unsigned      r;
		logic [CNT_W-1:0] count;
		logic             loaded;

		board = new();
		pace = 0;
		hold_request = 1'b0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= OP_LOAD;
		cfg_we        <= 1'b0;
		cfg_index     <= CFG_POINT_COUNT;
		cfg_data      <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Table not loaded after reset: fixed 0.2 whatever the energy.
		push_query(1);
		push_query(0);
		push_query(65535);
		drain_and_settle();

		// Five breakpoints, with a repeated wavelength in the middle and the
		// widest wavelength at the top.
		write_config(CNT_W'(5), 1'b1);
		push_load(0, WL_AT_1000MEV, 0);
		push_load(1, WL_AT_800MEV, 65535);
		push_load(2, WL_AT_800MEV, 12345);
		push_load(3, WL_AT_500MEV, 40000);
		push_load(4, WL_MAX, 65535);
		push_query(1000);   // equal to the first breakpoint: interval 0
		push_query(900);
		push_query(800);    // upper end of interval 0
		push_query(600);    // past the repeated wavelength
		push_query(500);
		push_query(499);
		push_query(1001);   // below the first breakpoint
		push_query(0);      // zero energy: infinite wavelength
		push_query(65535);
		push_query(1);      // wavelength wider than 24 bits
		push_query(2);      // lands in the top interval
		drain_and_settle();

		// Count below two acts as two; first interval has zero span.
		write_config(CNT_W'(0), 1'b1);
		push_load(0, WL_AT_1000MEV, 65535);
		push_load(1, WL_AT_1000MEV, 0);
		push_query(1000);
		push_query(999);
		push_load(0, 0, 65535);
		push_query(65535);
		push_load(63, $urandom(), $urandom_range(0, 65535));
		drain_and_settle();

		// Random phases: each writes the registers, loads an ascending table
		// over every slot in use, then mixes queries aimed into the table with
		// stray energies and stray loads.
		random_items = 0;
		phase = 0;
		while (random_items < RANDOM_ITEMS) begin
			r = $urandom_range(0, 19);
			case (r)
				0:       count = CNT_W'(0);
				1:       count = CNT_W'(1);
				2:       count = CNT_W'(64);
				3:       count = CNT_W'(127);
				4:       count = CNT_W'($urandom_range(65, 126));
				5, 6, 7: count = CNT_W'($urandom_range(9, 40));
				default: count = CNT_W'($urandom_range(2, 8));
			endcase
			used = count;
			if (used < 2)
				used = 2;
			if (used > TABLE_POINTS)
				used = TABLE_POINTS;
			loaded = ($urandom_range(0, 7) != 0);
			write_config(count, loaded);
			pace = $urandom_range(0, 2);

			// Build the ascending table.
			r = $urandom_range(0, 9);
			first_wl = (r == 0) ? $urandom_range(0, 300) : $urandom_range(300, 400000);
			r = $urandom_range(0, 9);
			if (r == 0)
				spread = $urandom_range(0, WL_MAX - first_wl);
			else if (r < 3)
				spread = $urandom_range(0, 2000000);
			else
				spread = $urandom_range(used, 60000);
			step_max = spread / (used - 1);
			if (step_max == 0)
				step_max = 1;
			wl_acc = first_wl;
			for (int unsigned s = 0; s < used; s++) begin
				if (s > 0 && $urandom_range(0, 15) != 0)
					wl_acc = wl_acc + $urandom_range(1, step_max);
				if (wl_acc > WL_MAX)
					wl_acc = WL_MAX;
				r = $urandom_range(0, 9);
				if (r == 0)
					eff = 0;
				else if (r == 1)
					eff = 65535;
				else
					eff = $urandom_range(0, 65535);
				push_load(s, wl_acc, eff);
				random_items++;
			end
			last_wl = wl_acc;

			// Now and then hold off the result side while items keep coming.
			if (phase % 8 == 0)
				hold_request = 1'b1;

			queries = $urandom_range(20, 60);
			for (int unsigned q = 0; q < queries; q++) begin
				r = $urandom_range(0, 99);
				if (r < 8) begin
					push_load($urandom_range(0, 63), $urandom_range(0, WL_MAX),
						$urandom_range(0, 65535));
				end else if (r < 25) begin
					push_query($urandom_range(0, 65535));
				end else begin
					target = $urandom_range(last_wl, first_wl);
					if (target == 0)
						target = 1;
					energy = (WL_ENERGY_PRODUCT + target / 2) / target;
					if (energy == 0)
						energy = 1;
					if (energy > 65535)
						energy = 65535;
					push_query(energy);
				end
				random_items++;
			end
			drain_and_settle();
			phase++;
		end

		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Hard stop well beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
